[rtl/bcd_pkg.sv]
`timescale 1ns / 1ps
package bcd_pkg;

  localparam int unsigned Entries    = 64;
  localparam int unsigned BlockBytes = 512;
  localparam int unsigned AddrBits   = 48;
  localparam int unsigned IdxW       = $clog2(Entries);
  localparam int unsigned OffW       = $clog2(BlockBytes);
  localparam int unsigned TagW       = AddrBits - OffW;
  localparam int unsigned RankW      = $clog2(Entries + 1);
  localparam int unsigned QDepth     = 2;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_FLUSH   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_GET  = 2'd0,
    OP_REL  = 2'd1,
    OP_IMM  = 2'd2
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [TagW-1:0]  tag;
    logic [IdxW-1:0]  idx;
    logic             use_held;
    logic             dirty;
    logic             status;
  } job_t;

  typedef struct packed {
    logic                status;
    logic [IdxW-1:0]     slot;
    logic                hit;
    logic                fill;
    logic                wb;
    logic [AddrBits-1:0] pos;
  } res_t;

endpackage

[rtl/block_cache_lru_directory.sv]
`timescale 1ns / 1ps
// Directory of a fully associative block cache with least-recently-released
// replacement.
// Input queue: push/full; a beat is taken when push is high and full
// is low. Fields: command, byte_position, slot_index, dirty.
// Result queue: empty/pop; the oldest result sits on the result ports
// while empty is low and leaves when pop is high.
// A front stage checks alignment and slot range and queues up to two
// commands; a back sequencer walks all 64 entries once (reads are registered)
// to search tags, find a free slot, count ranks and pick the victim, then (for
// release, and for flush with a slot held) walks them again to update ranks.
// Rejected and unused commands skip both walks.
// One command is executed at a time.
// Reset clears valid bits, per-entry rank-written flags and the hold; tags and
// rank storage need no clearing.
// A stalled result holds in its register; the back part waits for it to
// drain, and the front keeps taking beats until its queue fills.
module block_cache_lru_directory import bcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          command_i,
  input  logic [47:0]         byte_position_i,
  input  logic [5:0]          slot_index_i,
  input  logic                dirty_i,
  output logic                empty,
  input  logic                pop,
  output logic                status_o,
  output logic [5:0]          slot_o,
  output logic                hit_o,
  output logic                fill_request_o,
  output logic                writeback_request_o,
  output logic [47:0]         device_position_o
);

  logic job_valid, job_pop, res_valid;
  job_t job;
  res_t res;

  bcd_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .command_i,
    .byte_position_i, .slot_index_i, .dirty_i,
    .job_valid_o(job_valid), .job_o(job), .job_pop_i(job_pop)
  );

  bcd_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job), .job_pop_o(job_pop),
    .res_valid_o(res_valid), .res_o(res), .res_pop_i(pop)
  );

  assign empty               = !res_valid;
  assign status_o            = res.status;
  assign slot_o              = res.slot;
  assign hit_o               = res.hit;
  assign fill_request_o      = res.fill;
  assign writeback_request_o = res.wb;
  assign device_position_o   = res.pos;

endmodule

[rtl/bcd_front.sv]
`timescale 1ns / 1ps
module bcd_front import bcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [1:0]          command_i,
  input  logic [AddrBits-1:0] byte_position_i,
  input  logic [5:0]          slot_index_i,
  input  logic                dirty_i,
  output logic                job_valid_o,
  output job_t                job_o,
  input  logic                job_pop_i
);

  job_t          mem_q [QDepth];
  logic          wp_q, wp_d, rp_q, rp_d;
  logic [1:0]    cnt_q, cnt_d;
  job_t          job_in;
  logic          acc;

  assign full_o = (cnt_q == 2'(QDepth));
  assign acc    = push_i && !full_o;

  always_comb begin
    job_in          = '0;
    job_in.tag      = byte_position_i[AddrBits-1:OffW];
    job_in.idx      = IdxW'(slot_index_i);
    job_in.dirty    = dirty_i;
    case (cmd_e'(command_i))
      CMD_GET: begin
        if (byte_position_i[OffW-1:0] != '0) begin
          job_in.op     = OP_IMM;
          job_in.status = 1'b1;
          job_in.idx    = '0;
        end else begin
          job_in.op = OP_GET;
        end
      end
      CMD_RELEASE: begin
        if (32'(slot_index_i) >= Entries) begin
          job_in.op     = OP_IMM;
          job_in.status = 1'b1;
        end else begin
          job_in.op = OP_REL;
        end
      end
      CMD_FLUSH: begin
        job_in.op       = OP_REL;
        job_in.use_held = 1'b1;
        job_in.dirty    = 1'b1;
      end
      default: begin
        job_in.op  = OP_IMM;
        job_in.idx = '0;
      end
    endcase
  end

  assign job_valid_o = (cnt_q != '0);
  assign job_o       = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q + 1'(acc);
    rp_d  = rp_q + 1'(job_pop_i);
    cnt_d = cnt_q + 2'(acc) - 2'(job_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (acc) mem_q[wp_q] <= job_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/bcd_back.sv]
`timescale 1ns / 1ps
module bcd_back import bcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic job_pop_o,
  output logic res_valid_o,
  output res_t res_o,
  input  logic res_pop_i
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_APPLY  = 5'b00100,
    S_RANK   = 5'b01000,
    S_OUT    = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [TagW-1:0]     tag_mem [Entries];
  logic [RankW-1:0]    rank_mem [Entries];
  logic [TagW-1:0]     tag_rd_q;
  logic [RankW-1:0]    rank_rd_q;
  logic [Entries-1:0]  valid_q, valid_d;
  logic [Entries-1:0]  ranked_q, ranked_d;
  logic                held_v_q, held_v_d;
  logic [IdxW-1:0]     held_q, held_d;
  job_t                job_q, job_d;
  logic [IdxW-1:0]     ptr_q, ptr_d, p_q;
  logic                pv_q, pv_d;
  logic                hit_q, hit_d, free_q, free_d;
  logic [IdxW-1:0]     hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [IdxW-1:0]     min_idx_q, min_idx_d;
  logic [RankW-1:0]    min_q, min_d, n_q, n_d, old_q, old_d;
  logic [TagW-1:0]     wb_tag_q, wb_tag_d;
  logic [IdxW-1:0]     s_q, s_d;
  res_t                res_q, res_d;
  logic                res_v_q, res_v_d;
  logic [IdxW-1:0]     rd_idx, rd_addr, victim;
  logic [RankW-1:0]    rank_cur, rank_wd;
  logic                last, tag_we, rank_we;

  assign last        = (p_q == IdxW'(Entries - 1));
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;
  assign job_pop_o   = (state_q == S_IDLE) && job_valid_i && !res_v_q;
  assign rd_idx      = job_i.use_held ? held_q : job_i.idx;
  assign rd_addr     = (state_q == S_IDLE) ? rd_idx : ptr_q;
  assign rank_cur    = ranked_q[p_q] ? rank_rd_q : '0;
  assign victim      = free_q ? free_idx_q : min_idx_q;

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    ranked_d   = ranked_q;
    held_v_d   = held_v_q;
    held_d     = held_q;
    job_d      = job_q;
    ptr_d      = ptr_q;
    pv_d       = pv_q;
    hit_d      = hit_q;
    free_d     = free_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    min_idx_d  = min_idx_q;
    min_d      = min_q;
    n_d        = n_q;
    old_d      = old_q;
    wb_tag_d   = wb_tag_q;
    s_d        = s_q;
    res_d      = res_q;
    res_v_d    = res_v_q;
    tag_we     = 1'b0;
    rank_we    = 1'b0;
    rank_wd    = '0;
    if (res_v_q && res_pop_i) res_v_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        ptr_d     = '0;
        pv_d      = 1'b0;
        hit_d     = 1'b0;
        free_d    = 1'b0;
        n_d       = '0;
        min_d     = '1;
        min_idx_d = '0;
        s_d       = rd_idx;
        if (job_pop_o) begin
          job_d   = job_i;
          state_d = (job_i.op == OP_IMM) ? S_OUT : S_SCAN;
        end
      end
      S_SCAN: begin
        ptr_d = ptr_q + IdxW'(1);
        pv_d  = 1'b1;
        if (!pv_q) begin
          old_d    = rank_cur;
          wb_tag_d = tag_rd_q;
        end else begin
          if (rank_cur != '0) n_d = n_q + RankW'(1);
          if (!hit_q && valid_q[p_q] && tag_rd_q == job_q.tag) begin
            hit_d     = 1'b1;
            hit_idx_d = p_q;
          end
          if (!free_q && !valid_q[p_q]) begin
            free_d     = 1'b1;
            free_idx_d = p_q;
          end
          if (rank_cur < min_q) begin
            min_d     = rank_cur;
            min_idx_d = p_q;
          end
          if (last) state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        ptr_d   = '0;
        pv_d    = 1'b0;
        res_d   = '0;
        state_d = S_OUT;
        if (job_q.op == OP_GET) begin
          held_v_d = 1'b1;
          if (hit_q) begin
            held_d    = hit_idx_q;
            res_d.slot = hit_idx_q;
            res_d.hit  = 1'b1;
          end else begin
            held_d          = victim;
            valid_d[victim] = 1'b1;
            tag_we          = 1'b1;
            res_d.slot      = victim;
            res_d.fill      = 1'b1;
            res_d.pos       = {job_q.tag, OffW'(0)};
          end
        end else if (!(job_q.use_held && !held_v_q)) begin
          held_v_d   = 1'b0;
          held_d     = '0;
          res_d.slot = s_q;
          if (job_q.dirty && valid_q[s_q]) begin
            res_d.wb  = 1'b1;
            res_d.pos = {wb_tag_q, OffW'(0)};
          end
          state_d = S_RANK;
        end
      end
      S_RANK: begin
        ptr_d = ptr_q + IdxW'(1);
        pv_d  = 1'b1;
        if (pv_q) begin
          if (p_q == s_q) begin
            rank_we       = 1'b1;
            rank_wd       = (old_q == '0) ? n_q + RankW'(1) : n_q;
            ranked_d[p_q] = 1'b1;
          end else if (old_q != '0 && rank_cur > old_q) begin
            rank_we = 1'b1;
            rank_wd = rank_cur - RankW'(1);
          end
          if (last) state_d = S_OUT;
        end
      end
      S_OUT: begin
        res_v_d = 1'b1;
        state_d = S_IDLE;
        if (job_q.op == OP_IMM) begin
          res_d        = '0;
          res_d.status = job_q.status;
          res_d.slot   = job_q.idx;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    tag_rd_q  <= tag_mem[rd_addr];
    rank_rd_q <= rank_mem[rd_addr];
    if (tag_we) tag_mem[victim] <= job_q.tag;
    if (rank_we) rank_mem[p_q] <= rank_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      ranked_q   <= '0;
      held_v_q   <= 1'b0;
      held_q     <= '0;
      job_q      <= '0;
      ptr_q      <= '0;
      p_q        <= '0;
      pv_q       <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
      min_idx_q  <= '0;
      min_q      <= '0;
      n_q        <= '0;
      old_q      <= '0;
      wb_tag_q   <= '0;
      s_q        <= '0;
      res_q      <= '0;
      res_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      ranked_q   <= ranked_d;
      held_v_q   <= held_v_d;
      held_q     <= held_d;
      job_q      <= job_d;
      ptr_q      <= ptr_d;
      p_q        <= rd_addr;
      pv_q       <= pv_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
      hit_idx_q  <= hit_idx_d;
      free_idx_q <= free_idx_d;
      min_idx_q  <= min_idx_d;
      min_q      <= min_d;
      n_q        <= n_d;
      old_q      <= old_d;
      wb_tag_q   <= wb_tag_d;
      s_q        <= s_d;
      res_q      <= res_d;
      res_v_q    <= res_v_d;
    end
  end

endmodule

[rtl/bcd_checker.sv]
`timescale 1ns / 1ps
module bcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        status_o,
  input logic        hit_o,
  input logic        fill_request_o,
  input logic        writeback_request_o,
  input logic [47:0] device_position_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(device_position_o))
    else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> $countones({hit_o, fill_request_o, writeback_request_o}) <= 1)
    else $error("more than one outcome flagged");

  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o |-> !hit_o && !fill_request_o && !writeback_request_o)
    else $error("rejected command raised a request");

  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !fill_request_o && !writeback_request_o |-> device_position_o == '0)
    else $error("position without request");

endmodule

bind block_cache_lru_directory bcd_checker u_bcd_checker (
  .clk_i, .rst_ni, .empty, .pop, .status_o, .hit_o, .fill_request_o,
  .writeback_request_o, .device_position_o
);
